// ----- hdl/bryc_pkg.sv -----
// Shared types and constants of the bitmap RGB to YCbYCr converter.
package bryc_pkg;

  // Configuration port geometry and register indexes
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] RegPairsPerRow = 4'd0;
  localparam logic [CfgIdxW-1:0] RegRowCount    = 4'd1;

  // Field widths fixed by the block
  localparam int unsigned PprW  = 9;
  localparam int unsigned RowW  = 10;
  localparam int unsigned DestW = 18;

  // Phase of the sixth byte of a pixel pair
  localparam logic [2:0] LastPhase = 3'd5;

  // Luma weights, sum divided by 1000
  localparam logic [17:0] LumaR = 18'd299;
  localparam logic [17:0] LumaG = 18'd587;
  localparam logic [17:0] LumaB = 18'd114;

  // Chroma weights, numerator divided by 100000
  localparam logic [24:0] ChromaOff  = 25'd12800000;
  localparam logic [24:0] ChromaHalf = 25'd50000;
  localparam logic [24:0] CbR        = 25'd16874;
  localparam logic [24:0] CbG        = 25'd33126;
  localparam logic [24:0] CrG        = 25'd41869;
  localparam logic [24:0] CrB        = 25'd8131;

  // Reciprocals: ceil(2^shift / divisor), exact over the numerator ranges
  localparam logic [18:0] LumaRecip   = 19'd268436;
  localparam int unsigned LumaShift   = 28;
  localparam logic [24:0] ChromaRecip = 25'd21990233;
  localparam int unsigned ChromaShift = 41;

  // Input request: one bitmap byte
  typedef struct packed {
    logic [7:0] pixel_byte;
  } pixel_req_t;

  // Output request: one packed word and its place in the image
  typedef struct packed {
    logic [31:0]      packed_word;
    logic [DestW-1:0] dest_index;
    logic             last_word;
  } word_req_t;

  // Configuration write request
  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] value;
  } cfg_req_t;

  // Six bytes of one pixel pair
  typedef struct packed {
    logic [7:0] b1;
    logic [7:0] g1;
    logic [7:0] r1;
    logic [7:0] b2;
    logic [7:0] g2;
    logic [7:0] r2;
  } pair_t;

endpackage

// ----- hdl/bryc_chan_if.sv -----
// Valid/ready channel interface carrying one request payload.
interface bryc_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/bmp_rgb_to_ycbycr_converter_unit.sv -----
// Bitmap byte stream to packed YCbYCr 4:2:2 words with top-down word index.
//
//  channel  | dir | payload                               | handshake
//  ---------+-----+---------------------------------------+-------------
//  cfg_i    | in  | index, value (register write)         | valid/ready
//  pix_i    | in  | pixel_byte                            | valid/ready
//  word_o   | out | packed_word, dest_index, last_word    | valid/ready
//
//  One byte request is taken every cycle unless a sixth byte waits for room;
//  every sixth byte yields one word. A word shows on word_o after its sixth byte
//  request passes the pair, numerator and quotient registers and the output register.
//  Reset loads the saturated register defaults; there is no clearing pass.
//  A stalled output holds the pipe; only a sixth byte waits for room.
module bmp_rgb_to_ycbycr_converter_unit #(
  parameter int unsigned MAX_WIDTH = 640,
  parameter int unsigned MAX_ROWS  = 576
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bryc_chan_if.sink   cfg_i,
  bryc_chan_if.sink   pix_i,
  bryc_chan_if.source word_o
);

  localparam int unsigned PprMax = MAX_WIDTH / 2;
  localparam logic [bryc_pkg::PprW-1:0] PprRst =
    (PprMax < 320) ? bryc_pkg::PprW'(PprMax) : bryc_pkg::PprW'(320);
  localparam logic [bryc_pkg::RowW-1:0] RowRst =
    (MAX_ROWS < 480) ? bryc_pkg::RowW'(MAX_ROWS) : bryc_pkg::RowW'(480);

  // Clamp a written pairs-per-row value
  function automatic logic [bryc_pkg::PprW-1:0] sat_ppr(input logic [bryc_pkg::PprW-1:0] v);
    logic [bryc_pkg::PprW-1:0] r;
    r = (v == '0) ? bryc_pkg::PprW'(1) : v;
    if (32'(r) > PprMax) r = bryc_pkg::PprW'(PprMax);
    return r;
  endfunction

  // Clamp a written row count
  function automatic logic [bryc_pkg::RowW-1:0] sat_rows(input logic [bryc_pkg::RowW-1:0] v);
    logic [bryc_pkg::RowW-1:0] r;
    r = (v == '0) ? bryc_pkg::RowW'(1) : v;
    if (32'(r) > MAX_ROWS) r = bryc_pkg::RowW'(MAX_ROWS);
    return r;
  endfunction

  function automatic logic [17:0] luma_num(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
    return bryc_pkg::LumaR * 18'(r) + bryc_pkg::LumaG * 18'(g) + bryc_pkg::LumaB * 18'(b);
  endfunction

  function automatic logic [24:0] cb_num(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    return bryc_pkg::ChromaOff + bryc_pkg::ChromaHalf * 25'(b)
           - bryc_pkg::CbR * 25'(r) - bryc_pkg::CbG * 25'(g);
  endfunction

  function automatic logic [24:0] cr_num(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    return bryc_pkg::ChromaOff + bryc_pkg::ChromaHalf * 25'(r)
           - bryc_pkg::CrG * 25'(g) - bryc_pkg::CrB * 25'(b);
  endfunction

  // Divide by 1000 through the reciprocal
  function automatic logic [7:0] luma_div(input logic [17:0] n);
    logic [36:0] p;
    p = 37'(n) * 37'(bryc_pkg::LumaRecip);
    return p[bryc_pkg::LumaShift +: 8];
  endfunction

  // Divide by 100000 through the reciprocal
  function automatic logic [7:0] chroma_div(input logic [24:0] n);
    logic [49:0] p;
    p = 50'(n) * 50'(bryc_pkg::ChromaRecip);
    return p[bryc_pkg::ChromaShift +: 8];
  endfunction

  // Configuration and counter state
  logic [bryc_pkg::PprW-1:0] ppr_q, ppr_d;
  logic [bryc_pkg::RowW-1:0] rowcnt_q, rowcnt_d;
  logic [2:0]                phase_q, phase_d;
  logic [bryc_pkg::PprW-1:0] col_q, col_d;
  logic [bryc_pkg::RowW-1:0] rows_q, rows_d;
  logic [7:0]                held_q [5];

  // Pipeline registers
  logic                       a_vld_q;
  bryc_pkg::pair_t            a_pair_q;
  logic [bryc_pkg::RowW-1:0]  a_row_q;
  logic [bryc_pkg::PprW-1:0]  a_col_q;
  logic [bryc_pkg::PprW-1:0]  a_ppr_q;
  logic                       a_last_q;

  logic                       b_vld_q;
  logic [17:0]                b_yn1_q, b_yn2_q;
  logic [24:0]                b_cbn1_q, b_cbn2_q, b_crn1_q, b_crn2_q;
  logic [bryc_pkg::DestW-1:0] b_dest_q;
  logic                       b_last_q;

  logic                       c_vld_q;
  logic [7:0]                 c_y1_q, c_y2_q, c_cb1_q, c_cb2_q, c_cr1_q, c_cr2_q;
  logic [bryc_pkg::DestW-1:0] c_dest_q;
  logic                       c_last_q;

  logic                       o_vld_q;
  bryc_pkg::word_req_t        o_word_q;

  logic cfg_fire, pix_fire, group_fire;
  logic o_rdy, c_rdy, b_rdy, a_rdy;
  logic row_end, last_pair;
  logic [bryc_pkg::RowW-1:0] row_idx;
  logic [bryc_pkg::RowW+bryc_pkg::PprW-1:0] dest_prod;
  logic [8:0] cb_sum, cr_sum;

  // Backpressure chain from the output register to the byte input
  assign o_rdy = !o_vld_q || word_o.ready;
  assign c_rdy = !c_vld_q || o_rdy;
  assign b_rdy = !b_vld_q || c_rdy;
  assign a_rdy = !a_vld_q || b_rdy;

  assign cfg_i.ready = 1'b1;
  assign pix_i.ready = (phase_q != bryc_pkg::LastPhase) || a_rdy;

  assign cfg_fire   = cfg_i.valid && cfg_i.ready;
  assign pix_fire   = pix_i.valid && pix_i.ready;
  assign group_fire = pix_fire && (phase_q == bryc_pkg::LastPhase);

  // Position of the current pair in the bottom-up stream
  assign row_end   = ({1'b0, col_q} + 10'd1) >= {1'b0, ppr_q};
  assign last_pair = row_end && (rows_q <= bryc_pkg::RowW'(1));
  assign row_idx   = (rows_q != '0) ? rows_q - bryc_pkg::RowW'(1) : '0;

  // Next register, phase and counter values
  always_comb begin
    ppr_d    = ppr_q;
    rowcnt_d = rowcnt_q;
    phase_d  = phase_q;
    col_d    = col_q;
    rows_d   = rows_q;
    if (cfg_fire) begin
      if (cfg_i.data.index == bryc_pkg::RegPairsPerRow) begin
        ppr_d = sat_ppr(cfg_i.data.value[bryc_pkg::PprW-1:0]);
      end
      if (cfg_i.data.index == bryc_pkg::RegRowCount) begin
        rowcnt_d = sat_rows(cfg_i.data.value[bryc_pkg::RowW-1:0]);
      end
      if (cfg_i.data.index == bryc_pkg::RegPairsPerRow ||
          cfg_i.data.index == bryc_pkg::RegRowCount) begin
        phase_d = '0;
        col_d   = '0;
        rows_d  = rowcnt_d;
      end
    end else if (group_fire) begin
      phase_d = '0;
      if (last_pair) begin
        col_d  = '0;
        rows_d = rowcnt_q;
      end else if (row_end) begin
        col_d  = '0;
        rows_d = rows_q - bryc_pkg::RowW'(1);
      end else begin
        col_d = col_q + bryc_pkg::PprW'(1);
      end
    end else if (pix_fire) begin
      phase_d = phase_q + 3'd1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppr_q    <= PprRst;
      rowcnt_q <= RowRst;
      phase_q  <= '0;
      col_q    <= '0;
      rows_q   <= RowRst;
      a_vld_q  <= 1'b0;
      b_vld_q  <= 1'b0;
      c_vld_q  <= 1'b0;
      o_vld_q  <= 1'b0;
    end else begin
      ppr_q    <= ppr_d;
      rowcnt_q <= rowcnt_d;
      phase_q  <= phase_d;
      col_q    <= col_d;
      rows_q   <= rows_d;
      if (a_rdy) a_vld_q <= group_fire;
      if (b_rdy) b_vld_q <= a_vld_q;
      if (c_rdy) c_vld_q <= b_vld_q;
      if (o_rdy) o_vld_q <= c_vld_q;
    end
  end

  // Hold the first five bytes of a pair
  always_ff @(posedge clk_i) begin
    if (pix_fire && phase_q != bryc_pkg::LastPhase) begin
      held_q[phase_q] <= pix_i.data.pixel_byte;
    end
  end

  // Capture the completed pair and its position
  always_ff @(posedge clk_i) begin
    if (group_fire) begin
      a_pair_q.b1 <= held_q[0];
      a_pair_q.g1 <= held_q[1];
      a_pair_q.r1 <= held_q[2];
      a_pair_q.b2 <= held_q[3];
      a_pair_q.g2 <= held_q[4];
      a_pair_q.r2 <= pix_i.data.pixel_byte;
      a_row_q     <= row_idx;
      a_col_q     <= col_q;
      a_ppr_q     <= ppr_q;
      a_last_q    <= last_pair;
    end
  end

  // Form the weighted numerators and the word index
  assign dest_prod = (bryc_pkg::RowW + bryc_pkg::PprW)'(a_row_q) *
                     (bryc_pkg::RowW + bryc_pkg::PprW)'(a_ppr_q);

  always_ff @(posedge clk_i) begin
    if (b_rdy) begin
      b_yn1_q  <= luma_num(a_pair_q.r1, a_pair_q.g1, a_pair_q.b1);
      b_yn2_q  <= luma_num(a_pair_q.r2, a_pair_q.g2, a_pair_q.b2);
      b_cbn1_q <= cb_num(a_pair_q.r1, a_pair_q.g1, a_pair_q.b1);
      b_cbn2_q <= cb_num(a_pair_q.r2, a_pair_q.g2, a_pair_q.b2);
      b_crn1_q <= cr_num(a_pair_q.r1, a_pair_q.g1, a_pair_q.b1);
      b_crn2_q <= cr_num(a_pair_q.r2, a_pair_q.g2, a_pair_q.b2);
      b_dest_q <= bryc_pkg::DestW'(dest_prod +
                                   (bryc_pkg::RowW + bryc_pkg::PprW)'(a_col_q));
      b_last_q <= a_last_q;
    end
  end

  // Divide the numerators
  always_ff @(posedge clk_i) begin
    if (c_rdy) begin
      c_y1_q   <= luma_div(b_yn1_q);
      c_y2_q   <= luma_div(b_yn2_q);
      c_cb1_q  <= chroma_div(b_cbn1_q);
      c_cb2_q  <= chroma_div(b_cbn2_q);
      c_cr1_q  <= chroma_div(b_crn1_q);
      c_cr2_q  <= chroma_div(b_crn2_q);
      c_dest_q <= b_dest_q;
      c_last_q <= b_last_q;
    end
  end

  // Average the chroma pairs and pack the word
  assign cb_sum = {1'b0, c_cb1_q} + {1'b0, c_cb2_q};
  assign cr_sum = {1'b0, c_cr1_q} + {1'b0, c_cr2_q};

  always_ff @(posedge clk_i) begin
    if (o_rdy) begin
      o_word_q.packed_word <= {c_y1_q, cb_sum[8:1], c_y2_q, cr_sum[8:1]};
      o_word_q.dest_index  <= c_dest_q;
      o_word_q.last_word   <= c_last_q;
    end
  end

  assign word_o.valid = o_vld_q;
  assign word_o.data  = o_word_q;

endmodule

// ----- hdl/bryc_checker.sv -----
// Port-level assertions of the converter and their bind to the top level.
module bryc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                pix_valid_i,
  input logic                pix_ready_i,
  input logic                word_valid_i,
  input logic                word_ready_i,
  input bryc_pkg::word_req_t word_data_i
);

  // Reset empties the pipe
  assert property (@(posedge clk_i) !rst_ni |-> !word_valid_i)
    else $error("word request shown during reset");

  // Byte input stalls only behind a blocked output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_ready_i |-> (word_valid_i && !word_ready_i))
    else $error("byte input stalled while output is free");

  // A stalled word request holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (word_valid_i && !word_ready_i) |=> (word_valid_i && $stable(word_data_i)))
    else $error("stalled word request changed");

  // A refused byte request implies that a word request is shown on the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_valid_i && !pix_ready_i) |-> word_valid_i)
    else $error("byte request refused with empty output");

endmodule

bind bmp_rgb_to_ycbycr_converter_unit bryc_checker u_bryc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .pix_valid_i  (pix_i.valid),
  .pix_ready_i  (pix_i.ready),
  .word_valid_i (word_o.valid),
  .word_ready_i (word_o.ready),
  .word_data_i  (word_o.data)
);
